>>> rtl/lba_to_chs_translate_core_defines.svh
// Assertion macros shared by the translator RTL.
`ifndef LBA_TO_CHS_TRANSLATE_CORE_DEFINES_SVH
`define LBA_TO_CHS_TRANSLATE_CORE_DEFINES_SVH

// Condition implies a property in the same cycle, checked out of reset.
`define LBACHS_ASSERT_IMPL(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (expr)) else $error("translator check failed");

// Condition implies a property in the following cycle.
`define LBACHS_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error("translator check failed");

`endif

>>> rtl/lbachs_pkg.sv
// Shared constants and types for the LBA to CHS translator.
`default_nettype none
package lbachs_pkg;
    localparam int DRIVE_COUNT   = 4;
    localparam int SECTOR_BITS   = 28;
    localparam int NUM_GEOM_REGS = 4;
    localparam int CFG_IDX_W     = $clog2(NUM_GEOM_REGS);
    localparam int GEOM_W        = 32;
    localparam int DRV_W         = 2;
    localparam int CYL_OUT_W     = 28;

    // Sideband that rides along with a transaction through the dividers.
    typedef struct packed {
        logic       geom_ok;
        logic [7:0] heads;
        logic [15:0] cyls;
        logic [7:0] sec;
    } t_side;
endpackage
`default_nettype wire

>>> rtl/lbachs_divider.sv
// Pipelined restoring divider: one quotient bit per stage, 8-bit divisor.
`default_nettype none
module lbachs_divider import lbachs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [SECTOR_BITS-1:0] i_dividend,
    input  logic [7:0]             i_divisor,
    input  t_side                  i_side,
    output logic                   o_valid,
    output logic [SECTOR_BITS-1:0] o_quot,
    output logic [7:0]             o_rem,
    output t_side                  o_side
);
    logic                   r_valid [SECTOR_BITS];
    logic [SECTOR_BITS-1:0] r_dq    [SECTOR_BITS];
    logic [7:0]             r_rem   [SECTOR_BITS];
    logic [7:0]             r_div   [SECTOR_BITS];
    t_side                  r_side  [SECTOR_BITS];

    for (genvar k = 0; k < SECTOR_BITS; k++) begin : g_stage
        logic                   w_valid;
        logic [SECTOR_BITS-1:0] w_dq;
        logic [7:0]             w_rem;
        logic [7:0]             w_div;
        t_side                  w_side;
        logic [8:0]             w_trial;
        logic                   w_ge;
        logic [7:0]             n_rem;
        logic [SECTOR_BITS-1:0] n_dq;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_dq    = i_dividend;
            assign w_rem   = 8'd0;
            assign w_div   = i_divisor;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_dq    = r_dq[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_div   = r_div[k-1];
            assign w_side  = r_side[k-1];
        end

        // shift in next dividend bit, subtract if it fits
        always_comb begin
            w_trial = {w_rem, w_dq[SECTOR_BITS-1]};
            w_ge    = (w_trial >= {1'b0, w_div});
            n_rem   = w_ge ? 8'(w_trial - {1'b0, w_div}) : w_trial[7:0];
            n_dq    = {w_dq[SECTOR_BITS-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dq[k]   <= n_dq;
                r_rem[k]  <= n_rem;
                r_div[k]  <= w_div;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid = r_valid[SECTOR_BITS-1];
    assign o_quot  = r_dq[SECTOR_BITS-1];
    assign o_rem   = r_rem[SECTOR_BITS-1];
    assign o_side  = r_side[SECTOR_BITS-1];
endmodule
`default_nettype wire

>>> rtl/lba_to_chs_translate_core.sv
// Top level of the LBA to CHS translator: geometry registers, two dividers, output register.
`default_nettype none
`include "lba_to_chs_translate_core_defines.svh"
// Usage:
//   Input channel i_valid/o_ready carries one transaction: a drive index and a
//   28-bit absolute sector. Output channel o_valid/i_ready returns cylinder,
//   head, one-based sector and an in-range flag for each transaction, in order.
//   Geometry per drive is written through i_cfg_we/i_cfg_index/i_cfg_data
//   (spt in 7:0, heads in 15:8, cylinders in 31:16); write only while idle.
//   The path is a 28-stage divider for lba/spt, a 28-stage divider for
//   track/heads, then the output register.
//   Throughput is one transaction per cycle unless the receiver stalls; each
//   divider stage resolves one quotient bit with one 9-bit compare and subtract.
//   The whole pipeline moves on one enable, high when the output register is
//   empty or being taken. When the receiver stalls with a full output
//   register every stage holds, o_ready drops and nothing is lost.
//   Zero spt or heads gives all-zero fields and in_range low.
//   Reset (synchronous, active low) clears all stage valid bits and the
//   geometry registers.
module lba_to_chs_translate_core import lbachs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [DRV_W-1:0]       i_drive_index,
    input  logic [SECTOR_BITS-1:0] i_abs_sector,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [CYL_OUT_W-1:0]   o_cylinder,
    output logic [7:0]             o_head_number,
    output logic [7:0]             o_sector_number,
    output logic                   o_in_range,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [GEOM_W-1:0]      i_cfg_data
);
    logic [GEOM_W-1:0] r_geom [NUM_GEOM_REGS];

    logic                   w_en;
    logic [GEOM_W-1:0]      w_geom;
    t_side                  w_side_in;
    logic                   w_d1_valid;
    logic [SECTOR_BITS-1:0] w_d1_quot;
    logic [7:0]             w_d1_rem;
    t_side                  w_d1_side;
    t_side                  w_side_mid;
    logic                   w_d2_valid;
    logic [SECTOR_BITS-1:0] w_d2_quot;
    logic [7:0]             w_d2_rem;
    t_side                  w_d2_side;

    logic                   r_out_valid;
    logic [CYL_OUT_W-1:0]   r_cyl;
    logic [7:0]             r_head;
    logic [7:0]             r_sec;
    logic                   r_in_range;

    // geometry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_GEOM_REGS; i++) begin
                r_geom[i] <= '0;
            end
        end else if (i_cfg_we && (int'(i_cfg_index) < NUM_GEOM_REGS)) begin
            r_geom[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_en    = !r_out_valid || i_ready;
    assign o_ready = w_en;

    // drives beyond the populated count look like all-zero geometry
    always_comb begin
        w_geom = (int'(i_drive_index) < DRIVE_COUNT) ? r_geom[i_drive_index] : '0;
        w_side_in.geom_ok = (w_geom[7:0] != 8'd0) && (w_geom[15:8] != 8'd0);
        w_side_in.heads   = w_geom[15:8];
        w_side_in.cyls    = w_geom[31:16];
        w_side_in.sec     = 8'd0;
    end

    // sector = lba mod spt, track = lba div spt
    lbachs_divider u_div_spt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_valid),
        .i_dividend (i_abs_sector),
        .i_divisor  (w_geom[7:0]),
        .i_side     (w_side_in),
        .o_valid    (w_d1_valid),
        .o_quot     (w_d1_quot),
        .o_rem      (w_d1_rem),
        .o_side     (w_d1_side)
    );

    // remainder is below spt, so the one-based sector still fits 8 bits
    always_comb begin
        w_side_mid     = w_d1_side;
        w_side_mid.sec = w_d1_rem + 8'd1;
    end

    // head = track mod heads, cylinder = track div heads
    lbachs_divider u_div_heads (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_d1_valid),
        .i_dividend (w_d1_quot),
        .i_divisor  (w_d1_side.heads),
        .i_side     (w_side_mid),
        .o_valid    (w_d2_valid),
        .o_quot     (w_d2_quot),
        .o_rem      (w_d2_rem),
        .o_side     (w_d2_side)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_d2_side.geom_ok) begin
                r_cyl      <= CYL_OUT_W'(w_d2_quot);
                r_head     <= w_d2_rem;
                r_sec      <= w_d2_side.sec;
                r_in_range <= (w_d2_quot < SECTOR_BITS'(w_d2_side.cyls));
            end else begin
                r_cyl      <= '0;
                r_head     <= 8'd0;
                r_sec      <= 8'd0;
                r_in_range <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_cylinder      = r_cyl;
    assign o_head_number   = r_head;
    assign o_sector_number = r_sec;
    assign o_in_range      = r_in_range;

    // valid geometry always yields a sector of at least one
    `LBACHS_ASSERT_IMPL(a_range_has_sector, o_valid && o_in_range, o_sector_number != 8'd0)
    // invalid geometry zeroes every field
    `LBACHS_ASSERT_IMPL(a_zero_fields, o_valid && (o_sector_number == 8'd0),
        (o_cylinder == '0) && (o_head_number == 8'd0) && !o_in_range)
    // in-range cylinder fits the 16-bit cylinder count
    `LBACHS_ASSERT_IMPL(a_cyl_bound, o_valid && o_in_range, o_cylinder[CYL_OUT_W-1:16] == '0)
    // a stalled result keeps the pipeline frozen
    `LBACHS_ASSERT_NEXT(a_stall_freeze, o_valid && !i_ready,
        $stable(w_d2_valid) && $stable(w_d1_valid))
endmodule
`default_nettype wire
